@@ hdl/tcce_pkg.sv @@
// package for the text console cursor engine
// holds command codes, character codes and the command record shared by all modules
// no dependencies
package tcce_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CMD_DEPTH   = 2;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] CMD_PRINT     = 3'd0;
	localparam logic [2:0] CMD_NEWLINE   = 3'd1;
	localparam logic [2:0] CMD_BACKSPACE = 3'd2;
	localparam logic [2:0] CMD_RETURN    = 3'd3;
	localparam logic [2:0] CMD_TAB       = 3'd4;
	localparam logic [2:0] CMD_CLEAR     = 3'd5;
	localparam logic [2:0] CMD_SET       = 3'd6;
	localparam logic [2:0] CMD_READ      = 3'd7;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h07;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [6:0]  col;
		logic [4:0]  row;
		logic [10:0] addr;
		logic        in_range;
	} cmd_t;

endpackage

@@ hdl/text_console_cursor_engine.sv @@
// text console cursor engine, top level
// depends on tcce_pkg, tcce_front, tcce_cmd_fifo, tcce_back
//
// Commands enter on a queue-style port: a transaction happens when push is
// high and full is low. Each command gives one result on the result port:
// while empty is low the oldest result is shown, and pop with empty low
// takes it. The attribute register is written on the cfg channel (cfg_ready
// is always high) and should only change while the block is idle.
// A two-entry command queue sits between the classifying front end and the
// back end, so commands keep being taken while a result waits to be popped.
// Steps per command in the back end: set and put of a control or printable
// byte go from idle to done; read passes through a read state first;
// put that scrolls copies rows up one cell per cycle, then blanks the last
// row; clear blanks every cell, one cell per cycle.
// After reset the store is blanked with attribute 7 and full is high during
// that pass; the cursor is home and the attribute is 7.
// When the receiver does not pop, the back end holds its finished result and
// the queue fills, after which full goes high.
module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  new_column,
	input  logic [4:0]  new_row,
	input  logic [10:0] cell_address,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_location,
	output logic [15:0] read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0] attr_q;
	logic       fifo_full;
	logic       fifo_empty;
	logic       fifo_push;
	logic       fifo_pop;
	logic       busy;
	cmd_t       front_cmd;
	cmd_t       head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= ATTR_RESET;
		else if (cfg_valid)
			attr_q <= cfg_data;
	end

	tcce_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.char_code    (char_code),
		.new_column   (new_column),
		.new_row      (new_row),
		.cell_address (cell_address),
		.fifo_full    (fifo_full),
		.busy         (busy),
		.fifo_push    (fifo_push),
		.cmd          (front_cmd)
	);

	tcce_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wr_cmd (front_cmd),
		.full   (fifo_full),
		.empty  (fifo_empty),
		.pop    (fifo_pop),
		.rd_cmd (head_cmd)
	);

	tcce_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (head_cmd),
		.cmd_empty       (fifo_empty),
		.cmd_pop         (fifo_pop),
		.busy            (busy),
		.attr            (attr_q),
		.pop             (pop),
		.empty           (empty),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.read_data       (read_data)
	);

endmodule

@@ hdl/tcce_front.sv @@
// front end: input handshake and command classification
// depends on tcce_pkg
module tcce_front import tcce_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  new_column,
	input  logic [4:0]  new_row,
	input  logic [10:0] cell_address,
	input  logic        fifo_full,
	input  logic        busy,
	output logic        fifo_push,
	output cmd_t        cmd
);

	localparam logic [6:0]  LAST_COL = 7'(COLUMNS - 1);
	localparam logic [4:0]  LAST_ROW = 5'(ROWS - 1);
	localparam logic [12:0] CELLS    = 13'(COLUMNS * ROWS);

	assign full      = fifo_full | busy;
	assign fifo_push = push & ~full;

	always_comb begin
		cmd.ch       = char_code;
		cmd.addr     = cell_address;
		cmd.in_range = ({2'b00, cell_address} < CELLS);
		cmd.col      = (new_column > LAST_COL) ? LAST_COL : new_column;
		cmd.row      = (new_row > LAST_ROW) ? LAST_ROW : new_row;
		case (opcode)
			OP_PUT: begin
				case (char_code)
					CH_NEWLINE:   cmd.kind = CMD_NEWLINE;
					CH_BACKSPACE: cmd.kind = CMD_BACKSPACE;
					CH_RETURN:    cmd.kind = CMD_RETURN;
					CH_TAB:       cmd.kind = CMD_TAB;
					default:      cmd.kind = CMD_PRINT;
				endcase
			end
			OP_CLEAR: cmd.kind = CMD_CLEAR;
			OP_SET:   cmd.kind = CMD_SET;
			default:  cmd.kind = CMD_READ;
		endcase
	end

endmodule

@@ hdl/tcce_cmd_fifo.sv @@
// short command queue between front and back end
// depends on tcce_pkg
module tcce_cmd_fifo import tcce_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	output logic empty,
	input  logic pop,
	output cmd_t rd_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hdl/tcce_back.sv @@
// back end: cell store, cursor, scroll and clear sequencer, result register
// depends on tcce_pkg
module tcce_back import tcce_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	output logic        busy,
	input  logic [7:0]  attr,
	input  logic        pop,
	output logic        empty,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_location,
	output logic [15:0] read_data
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int MOVE   = CELLS - COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'(MOVE - 1);
	localparam logic [ADDR_W-1:0] MOVE_START = ADDR_W'(MOVE);
	localparam logic [ADDR_W-1:0] COL_OFS    = ADDR_W'(COLUMNS);
	localparam logic [6:0] LAST_COL  = 7'(COLUMNS - 1);
	localparam logic [4:0] LAST_ROW  = 5'(ROWS - 1);
	localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
	localparam logic [5:0] ROW_LIMIT = 6'(ROWS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_TAIL   = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [15:0]       mem_q [CELLS];
	logic [15:0]       mem_rd_q;
	logic [2:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [6:0]        col_q;
	logic [4:0]        row_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic              rd_range_q;
	logic [15:0]       res_data_q;
	logic              out_valid_q;
	logic [6:0]        out_col_q;
	logic [4:0]        out_row_q;
	logic [10:0]       out_loc_q;
	logic [15:0]       out_data_q;

	logic [ADDR_W-1:0] cur_addr;
	logic              out_free;
	logic              out_load;
	logic [7:0]        ncol;
	logic [5:0]        nrow;
	logic              scroll_need;
	logic              we;
	logic              re;
	logic [ADDR_W-1:0] wa;
	logic [ADDR_W-1:0] ra;
	logic [15:0]       wd;

	assign cur_addr  = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign out_free  = ~out_valid_q | pop;
	assign out_load  = (state_q == ST_DONE) & out_free;
	assign cmd_pop   = (state_q == ST_IDLE) & ~cmd_empty;
	assign busy      = (state_q == ST_INIT);

	assign empty           = ~out_valid_q;
	assign cursor_column   = out_col_q;
	assign cursor_row      = out_row_q;
	assign cursor_location = out_loc_q;
	assign read_data       = out_data_q;

	// cursor movement for put commands
	always_comb begin
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		case (cmd.kind)
			CMD_NEWLINE: begin
				ncol = '0;
				nrow = nrow + 1'b1;
			end
			CMD_BACKSPACE: begin
				if (col_q != '0) begin
					ncol = ncol - 1'b1;
				end else if (row_q != '0) begin
					nrow = nrow - 1'b1;
					ncol = {1'b0, LAST_COL};
				end
			end
			CMD_RETURN: ncol = '0;
			CMD_TAB:    ncol = (ncol + 8'd8) & ~8'd7;
			default:    ncol = ncol + 1'b1;
		endcase
		if (ncol >= COL_LIMIT) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end
		scroll_need = (nrow >= ROW_LIMIT);
		if (scroll_need)
			nrow = {1'b0, LAST_ROW};
	end

	// store port selection
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = cnt_q;
		ra = cnt_q + COL_OFS;
		wd = {attr, CH_SPACE};
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wd = {ATTR_RESET, CH_SPACE};
			end
			ST_IDLE: begin
				if (cmd_pop && cmd.kind == CMD_PRINT) begin
					we = 1'b1;
					wa = cur_addr;
					wd = {attr, cmd.ch};
				end
				if (cmd_pop && cmd.kind == CMD_READ && cmd.in_range) begin
					re = 1'b1;
					ra = ADDR_W'(cmd.addr);
				end
			end
			ST_SCROLL: begin
				re = 1'b1;
				we = pend_s1;
				wa = dst_s1;
				wd = mem_rd_q;
			end
			ST_TAIL: begin
				we = pend_s1;
				wa = dst_s1;
				wd = mem_rd_q;
			end
			ST_FILL: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		if (re)
			mem_rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							CMD_SET: begin
								col_q   <= cmd.col;
								row_q   <= cmd.row;
								state_q <= ST_DONE;
							end
							CMD_READ: state_q <= ST_READ;
							default: begin
								col_q <= ncol[6:0];
								row_q <= nrow[4:0];
								cnt_q <= '0;
								state_q <= scroll_need ? ST_SCROLL : ST_DONE;
							end
						endcase
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_SCROLL: begin
					pend_s1 <= 1'b1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == LAST_MOVE)
						state_q <= ST_TAIL;
				end
				ST_TAIL: begin
					pend_s1 <= 1'b0;
					cnt_q   <= MOVE_START;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL)
			dst_s1 <= cnt_q;
		if (cmd_pop) begin
			rd_range_q <= cmd.in_range;
			res_data_q <= '0;
		end
		if (state_q == ST_READ)
			res_data_q <= rd_range_q ? mem_rd_q : 16'h0000;
		if (out_load) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_loc_q  <= 11'(cur_addr);
			out_data_q <= res_data_q;
		end
	end

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= LAST_COL) && (row_q <= LAST_ROW))
		else $error("cursor left the screen");

	a_pend_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCROLL || state_q == ST_TAIL))
		else $error("copy write pending outside scroll");

	a_idle_write_print: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && we) |-> (!cmd_empty && cmd.kind == CMD_PRINT))
		else $error("store write in idle without print command");

	a_tail_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |=> (state_q == ST_FILL && cnt_q == MOVE_START))
		else $error("bottom row fill not started at last row");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without finished command");

endmodule
